// File: sv/ole_pkg.sv
// shared constants and types for the ordered list engine
`timescale 1ns / 1ps
`default_nettype none
package ole_pkg;
    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [AW-1:0]        t_addr;
    typedef logic [CW-1:0]        t_cnt;

    localparam logic [3:0] ACT_INS_FRONT = 4'd0;
    localparam logic [3:0] ACT_INS_BACK  = 4'd1;
    localparam logic [3:0] ACT_INS_AT    = 4'd2;
    localparam logic [3:0] ACT_RM_FRONT  = 4'd3;
    localparam logic [3:0] ACT_RM_BACK   = 4'd4;
    localparam logic [3:0] ACT_RM_AT     = 4'd5;
    localparam logic [3:0] ACT_RM_VALUE  = 4'd6;
    localparam logic [3:0] ACT_FIND      = 4'd7;
    localparam logic [3:0] ACT_REPLACE   = 4'd8;
    localparam logic [3:0] ACT_MAX       = 4'd9;
    localparam logic [3:0] ACT_MIN       = 4'd10;
    localparam logic [3:0] ACT_RM_BOTH   = 4'd11;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
endpackage
`default_nettype wire

// File: sv/ole_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/ordered_list_engine.sv
// ordered list engine top level: sequencer walking the entry memory
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  ports
// in       sink       i_valid/o_ready, i_action i_value i_position i_new_value
// out      source     o_valid/i_ready, o_status o_data o_found_position
//                     o_match_count o_entry_count o_is_full o_is_empty
// with no walk, a taken word passes through S_IDLE, S_DEC and S_DONE before its result is
// registered; a walk visits one memory entry a cycle through the single read and write
// ports, shifting entries for an insert or a remove and scanning them for find, replace,
// max and min; a remove by value does a scan and then a shift.
// reset clears count and control only; the entry ram is not cleared.
// a new word is taken while the previous result still waits in the output register,
// but the walk for it starts only once that result has been taken.
module ordered_list_engine
    import ole_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_action,
    input  wire logic [31:0] i_value,
    input  wire logic [6:0]  i_position,
    input  wire logic [31:0] i_new_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [31:0]      o_data,
    output logic [5:0]       o_found_position,
    output logic [6:0]       o_match_count,
    output logic [6:0]       o_entry_count,
    output logic             o_is_full,
    output logic             o_is_empty
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_UP    = 3'd2;
    localparam logic [2:0] S_DOWN  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_have, n_have;     // input word held
    logic [3:0] r_act;
    t_word      r_val, r_nval;
    logic [6:0] r_pos;
    t_cnt       r_count, n_count;
    // walk control
    t_cnt       r_idx, n_idx;       // walk address (read at idx-1 when shifting up)
    t_cnt       r_stop, n_stop;
    logic       r_rv, n_rv;         // read data in rdata valid
    t_cnt       r_ridx, n_ridx;     // address of data in rdata
    logic       r_hit, n_hit;
    t_cnt       r_fidx, n_fidx;
    t_word      r_best, n_best;
    t_cnt       r_mc, n_mc;
    logic [2:0] r_st, n_st;
    t_word      r_dat, n_dat;
    t_cnt       r_fp, n_fp;
    logic       r_ov, n_ov;
    logic [2:0] r_ost, n_ost;
    t_word      r_odat, n_odat;
    t_cnt       r_ofp, n_ofp, r_omc, n_omc;

    logic  we;
    t_cnt  waddr, raddr;
    t_word wdata, rdata;

    ole_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr[AW-1:0]),
        .i_wdata(wdata),
        .i_raddr(raddr[AW-1:0]),
        .o_rdata(rdata)
    );

    function automatic logic key_gt(input t_word a, input t_word b);
        return $signed(a) > $signed(b);
    endfunction

    assign o_ready = !r_have;
    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_data = r_odat;
    assign o_found_position = r_ofp[5:0];
    assign o_match_count = r_omc;
    assign o_entry_count = r_count;
    assign o_is_full = (r_count == t_cnt'(DEPTH));
    assign o_is_empty = (r_count == '0);

    always_comb begin
        logic  in_acc;
        logic  better;
        t_cnt  tgt;
        in_acc = i_valid && o_ready;
        n_state = r_state; n_have = r_have; n_count = r_count;
        n_idx = r_idx; n_stop = r_stop; n_rv = 1'b0; n_ridx = r_idx;
        n_hit = r_hit; n_fidx = r_fidx; n_best = r_best; n_mc = r_mc;
        n_st = r_st; n_dat = r_dat; n_fp = r_fp;
        n_ov = r_ov; n_ost = r_ost; n_odat = r_odat; n_ofp = r_ofp; n_omc = r_omc;
        we = 1'b0; waddr = r_idx; wdata = r_val; raddr = r_idx;
        better = 1'b0; tgt = '0;
        if (r_ov && i_ready) n_ov = 1'b0;
        if (in_acc) n_have = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (r_have && !(r_ov && !i_ready)) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_st = ST_OK; n_dat = '0; n_fp = '0; n_mc = '0;
                n_hit = 1'b0; n_state = S_DONE;
                unique case (r_act) inside
                    ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
                        tgt = (r_act == ACT_INS_FRONT) ? t_cnt'(0) :
                              (r_act == ACT_INS_BACK) ? r_count : t_cnt'(r_pos);
                        if (r_count == t_cnt'(DEPTH)) n_st = ST_FULL;
                        else if (tgt > r_count) n_st = ST_BADPOS;
                        else begin
                            // shift up from the top: read i-1, write i
                            n_fidx = tgt;
                            n_stop = tgt;
                            n_idx = r_count;
                            n_state = S_UP;
                        end
                    end
                    ACT_RM_FRONT, ACT_RM_BACK, ACT_RM_AT, ACT_RM_BOTH: begin
                        tgt = (r_act == ACT_RM_BACK) ? r_count - 1'b1 :
                              (r_act == ACT_RM_AT) ? t_cnt'(r_pos) : t_cnt'(0);
                        if (r_count == '0) n_st = ST_EMPTY;
                        else if (tgt >= r_count) n_st = ST_BADPOS;
                        else begin
                            n_fp = tgt;
                            n_fidx = tgt;
                            n_idx = tgt;
                            n_state = S_DOWN;
                        end
                    end
                    ACT_RM_VALUE, ACT_FIND, ACT_MAX, ACT_MIN, ACT_REPLACE: begin
                        if (r_count == '0) begin
                            if (r_act != ACT_REPLACE) n_st = ST_EMPTY;
                        end else begin
                            n_idx = '0;
                            n_state = S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            S_UP: begin
                // pipeline: read addr idx-1, write previous read to ridx+1
                if (r_rv) begin
                    we = 1'b1; waddr = r_ridx + 1'b1; wdata = rdata;
                end
                if (r_idx > r_stop) begin
                    raddr = r_idx - 1'b1;
                    n_ridx = r_idx - 1'b1;
                    n_rv = 1'b1;
                    n_idx = r_idx - 1'b1;
                end else if (!r_rv) begin
                    we = 1'b1; waddr = r_fidx; wdata = r_val;
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DOWN: begin
                // read idx, write to idx-1 (first read is removed word)
                if (r_rv) begin
                    if (r_ridx == r_fidx) n_dat = rdata;
                    else begin
                        we = 1'b1; waddr = r_ridx - 1'b1; wdata = rdata;
                    end
                end
                if (r_idx < r_count) begin
                    raddr = r_idx; n_ridx = r_idx; n_rv = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else if (!r_rv) begin
                    n_count = r_count - 1'b1;
                    if (r_act == ACT_RM_BOTH && r_count > t_cnt'(1)) begin
                        n_count = r_count - 2'd2;
                    end
                    n_state = S_DONE;
                end
            end
            default: begin // S_SCAN
                if (r_rv) begin
                    case (r_act) inside
                        ACT_REPLACE: begin
                            if (rdata == r_val) begin
                                we = 1'b1; waddr = r_ridx; wdata = r_nval;
                                n_mc = r_mc + 1'b1;
                            end
                        end
                        ACT_MAX, ACT_MIN: begin
                            better = (r_act == ACT_MAX) ? key_gt(rdata, r_best)
                                                        : key_gt(r_best, rdata);
                            if (r_ridx == '0 || better) n_best = rdata;
                        end
                        default: begin
                            if (!r_hit && rdata == r_val) begin
                                n_hit = 1'b1; n_fidx = r_ridx;
                            end
                        end
                    endcase
                end
                if (r_idx < r_count) begin
                    raddr = r_idx; n_ridx = r_idx; n_rv = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else if (!r_rv) begin
                    n_state = S_DONE;
                    n_mc = r_mc;
                    if (r_act == ACT_MAX || r_act == ACT_MIN) n_dat = r_best;
                    else if (r_act == ACT_FIND || r_act == ACT_RM_VALUE) begin
                        if (!r_hit) n_st = ST_NOTFOUND;
                        else begin
                            n_fp = r_fidx;
                            if (r_act == ACT_RM_VALUE) begin
                                n_idx = r_fidx;
                                n_state = S_DOWN;
                            end
                        end
                    end
                end
            end
            S_DONE: begin
                n_ov = 1'b1; n_ost = r_st; n_odat = r_dat; n_ofp = r_fp;
                n_omc = r_mc; n_have = 1'b0; n_state = S_IDLE;
            end
        endcase
        if (r_state == S_DONE && in_acc) n_have = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_have  <= 1'b0;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_have  <= n_have;
            r_count <= n_count;
            r_ov    <= n_ov;
            r_rv    <= n_rv;
        end
        if (i_valid && o_ready) begin
            r_act  <= i_action;
            r_val  <= i_value;
            r_pos  <= i_position;
            r_nval <= i_new_value;
        end
        r_idx <= n_idx; r_stop <= n_stop; r_ridx <= n_ridx; r_hit <= n_hit;
        r_fidx <= n_fidx; r_best <= n_best; r_mc <= n_mc; r_st <= n_st;
        r_dat <= n_dat; r_fp <= n_fp; r_ost <= n_ost; r_odat <= n_odat;
        r_ofp <= n_ofp; r_omc <= n_omc;
    end
endmodule
`default_nettype wire
